// ===== hw/rtl/stwec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stwec_pkg;

  localparam int RING_DEPTH_DEF = 1024;

  localparam int TIME_W  = 48;
  localparam int UNIT_W  = 2;
  localparam int DUR_W   = 31;
  localparam int SCALE_W = 22;
  localparam int LEN_W   = DUR_W + SCALE_W;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DUR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_UNIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_VALUE = CFG_IDX_W'(1);

  localparam logic [UNIT_W-1:0] UNIT_HOURS   = UNIT_W'(0);
  localparam logic [UNIT_W-1:0] UNIT_MINUTES = UNIT_W'(1);

  localparam logic [SCALE_W-1:0] MS_PER_HOUR   = SCALE_W'(3600000);
  localparam logic [SCALE_W-1:0] MS_PER_MINUTE = SCALE_W'(60000);
  localparam logic [SCALE_W-1:0] MS_PER_SECOND = SCALE_W'(1000);

  localparam logic [UNIT_W-1:0] DUR_UNIT_RST  = UNIT_HOURS;
  localparam logic [DUR_W-1:0]  DUR_VALUE_RST = DUR_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic store;
    logic read;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic slide;
    logic scan_more;
  } status_t;

  function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] unit);
    logic [SCALE_W-1:0] s;
    case (unit)
      UNIT_HOURS:   s = MS_PER_HOUR;
      UNIT_MINUTES: s = MS_PER_MINUTE;
      default:      s = MS_PER_SECOND;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stwec_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stwec_in_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [stwec_pkg::TIME_W-1:0]  event_start_ms;
  logic [stwec_pkg::TIME_W-1:0]  event_end_ms;

  modport source (output valid, restart, event_start_ms, event_end_ms, input ready);
  modport sink   (input valid, restart, event_start_ms, event_end_ms, output ready);
endinterface

interface stwec_out_if;
  logic                          valid;
  logic                          ready;
  logic [stwec_pkg::COUNT_W-1:0] event_count;
  logic                          overflow;

  modport source (output valid, event_count, overflow, input ready);
  modport sink   (input valid, event_count, overflow, output ready);
endinterface

interface stwec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [stwec_pkg::CFG_IDX_W-1:0]  index;
  logic [stwec_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sliding_time_window_event_count.sv =====
// Sliding time-window event counter.
// in_ch  : one beat per event (restart, event_start_ms, event_end_ms).
// out_ch : one beat per event (event_count, overflow), in event order.
// cfg_ch : register writes, index 0 duration_unit, 1 duration_value; always ready.
//          Write only while no event is in flight.
// An event is taken in the idle state; the store state and then the result
// (finish) state follow when the window does not slide. A sliding event walks
// the oldest pointer through the ring between store and finish, one registered
// memory read and one compare per entry.
// The single ring read port paces the walk; each entry is dropped once.
// out_ch.valid is registered from the finish state, which follows the store
// state and any read/compare pairs of the walk.
// The result sits in an output register; the next event is taken while it
// waits, and the sequencer holds in its last step only if an older result
// is still unread when the new one is ready.
// Reset (rst_n, synchronous) empties the window, zeroes the window end and
// loads unit hours, value 1. Ring contents are not cleared; no sweep needed.
`timescale 1ns / 1ps
`default_nettype none

module sliding_time_window_event_count #(
  parameter int RING_DEPTH = stwec_pkg::RING_DEPTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  stwec_in_if.sink     in_ch,
  stwec_out_if.source  out_ch,
  stwec_cfg_if.sink    cfg_ch
);

  stwec_pkg::cmd_t    cmd;
  stwec_pkg::status_t status;

  assign cfg_ch.ready = 1'b1;

  stwec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  stwec_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .in_restart  (in_ch.restart),
    .in_start_ms (in_ch.event_start_ms),
    .in_end_ms   (in_ch.event_end_ms),
    .cmd         (cmd),
    .status      (status),
    .event_count (out_ch.event_count),
    .overflow    (out_ch.overflow)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/stwec_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stwec_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire stwec_pkg::status_t status,
  output stwec_pkg::cmd_t         cmd
);

  stwec_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stwec_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stwec_pkg::ST_IDLE:     if (in_valid) state_nxt = stwec_pkg::ST_STORE;
      stwec_pkg::ST_STORE:    state_nxt = status.slide ? stwec_pkg::ST_SCAN_RD
                                                       : stwec_pkg::ST_FINISH;
      stwec_pkg::ST_SCAN_RD:  state_nxt = stwec_pkg::ST_SCAN_CMP;
      stwec_pkg::ST_SCAN_CMP: state_nxt = status.scan_more ? stwec_pkg::ST_SCAN_RD
                                                           : stwec_pkg::ST_FINISH;
      stwec_pkg::ST_FINISH:   if (out_free) state_nxt = stwec_pkg::ST_IDLE;
      default:                state_nxt = stwec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      stwec_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      stwec_pkg::ST_STORE:    cmd.store  = 1'b1;
      stwec_pkg::ST_SCAN_RD:  cmd.read   = 1'b1;
      stwec_pkg::ST_SCAN_CMP: cmd.step   = status.scan_more;
      stwec_pkg::ST_FINISH:   cmd.finish = out_free;
      default: ;
    endcase
    // result register drains independently of the sequencer
    out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && !out_ready);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stwec_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stwec_dp #(
  parameter int RING_DEPTH = stwec_pkg::RING_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [stwec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stwec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              in_restart,
  input  wire logic [stwec_pkg::TIME_W-1:0]      in_start_ms,
  input  wire logic [stwec_pkg::TIME_W-1:0]      in_end_ms,
  input  wire stwec_pkg::cmd_t                   cmd,
  output stwec_pkg::status_t                     status,
  output logic [stwec_pkg::COUNT_W-1:0]          event_count,
  output logic                                   overflow
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int TW     = stwec_pkg::TIME_W;
  localparam int LW     = stwec_pkg::LEN_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);
  localparam logic [TW:0]       TIME_MAX  = {1'b0, {TW{1'b1}}};

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  // configuration and window length
  logic [stwec_pkg::UNIT_W-1:0] unit_r;
  logic [stwec_pkg::DUR_W-1:0]  dur_r;
  logic [LW-1:0]                len_r, len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= stwec_pkg::DUR_UNIT_RST;
      dur_r  <= stwec_pkg::DUR_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stwec_pkg::CFG_DURATION_UNIT:  unit_r <= cfg_data[stwec_pkg::UNIT_W-1:0];
        stwec_pkg::CFG_DURATION_VALUE: dur_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_nxt = LW'(dur_r) * LW'(stwec_pkg::unit_scale(unit_r));

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  // item latch
  logic          restart_r;
  logic [TW-1:0] start_r, end_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      restart_r <= in_restart;
      start_r   <= in_start_ms;
      end_r     <= in_end_ms;
    end
  end

  // window state
  logic [SLOT_W-1:0] write_r, oldest_r;
  logic [CNT_W-1:0]  held_r;
  logic [TW-1:0]     window_end_r, win_start_r, rd_r;
  logic              ovf_r, full, slide;
  logic [TW:0]       we_sum;
  logic [TW-1:0]     we_sat, win_start_nxt;
  logic [LW-1:0]     end_ext;

  assign full    = (held_r == FULL_CNT);
  assign slide   = !restart_r && (end_r > window_end_r);
  assign we_sum  = {1'b0, start_r} + (TW+1)'(len_r);
  assign we_sat  = ((len_r > LW'(TIME_MAX)) || (we_sum > TIME_MAX)) ? TIME_MAX[TW-1:0]
                                                                      : we_sum[TW-1:0];
  assign end_ext = LW'(end_r);
  assign win_start_nxt = (end_ext > len_r) ? (end_r - len_r[TW-1:0]) : '0;

  assign status.slide     = slide;
  assign status.scan_more = (held_r > CNT_W'(1)) && (rd_r < win_start_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_r      <= '0;
      oldest_r     <= '0;
      held_r       <= '0;
      window_end_r <= '0;
    end else if (cmd.store) begin
      if (restart_r) begin
        window_end_r <= we_sat;
        oldest_r     <= '0;
        held_r       <= CNT_W'(1);
        write_r      <= next_slot('0);
      end else begin
        // full ring: drop oldest, count stays put
        if (full) oldest_r <= next_slot(oldest_r);
        else      held_r   <= held_r + CNT_W'(1);
        write_r <= next_slot(write_r);
        if (slide) window_end_r <= end_r;
      end
    end else if (cmd.step) begin
      oldest_r <= next_slot(oldest_r);
      held_r   <= held_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ovf_r       <= !restart_r && full;
      win_start_r <= win_start_nxt;
    end
  end

  // end-time ring
  logic [TW-1:0] ring [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.store) ring[restart_r ? '0 : write_r] <= end_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) rd_r <= ring[oldest_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      event_count <= restart_r ? '0 : stwec_pkg::COUNT_W'(held_r);
      overflow    <= ovf_r;
    end
  end

endmodule

`default_nettype wire
